// ===== design/serial_frame_deframer_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the serial frame deframer
// Concurrent assertion wrappers that compile away when NO_ASSERTIONS is set.
// ---------------------------------------------------------------------------
`ifndef SERIAL_FRAME_DEFRAMER_TOP_MACROS_SVH
`define SERIAL_FRAME_DEFRAMER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SFD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SFD_ASSERT(lbl, clk, rst_n, prop, msg)
`define SFD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== design/sfd_pkg.sv =====
// ---------------------------------------------------------------------------
// Serial frame deframer package
// Phase codes, register indexes, result kinds and shared structures.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfd_pkg;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_STOP_BYTE  = CFG_IDX_W'(1);

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_CMD_HI  = 4'd1,
    PH_CMD_LO  = 4'd2,
    PH_NODE    = 4'd3,
    PH_EXT_HI  = 4'd4,
    PH_EXT_LO  = 4'd5,
    PH_LENGTH  = 4'd6,
    PH_PAYLOAD = 4'd7,
    PH_STOP    = 4'd8
  } phase_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] stop_byte;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] command;
    logic [7:0]  node_id;
    logic [15:0] ext_id;
    logic [7:0]  payload_length;
    logic [7:0]  payload_index;
    logic [7:0]  payload_byte;
    logic        frame_error;
  } res_t;

  typedef struct packed {
    logic       step;
    logic [7:0] rx_byte;
  } stage_t;

  typedef struct packed {
    logic en;
    res_t res;
  } parse_out_t;

endpackage

// ===== design/sfd_if.sv =====
// ---------------------------------------------------------------------------
// Serial frame deframer channels
// Valid/ready channels for received bytes and for deframer results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] command;
  logic [7:0]  node_id;
  logic [15:0] ext_id;
  logic [7:0]  payload_length;
  logic [7:0]  payload_index;
  logic [7:0]  payload_byte;
  logic        frame_error;

  modport source (output valid, output kind, output command, output node_id,
                  output ext_id, output payload_length, output payload_index,
                  output payload_byte, output frame_error, input ready);
  modport sink (input valid, input kind, input command, input node_id,
                input ext_id, input payload_length, input payload_index,
                input payload_byte, input frame_error, output ready);
endinterface

// ===== design/sfd_in_stage.sv =====
// ---------------------------------------------------------------------------
// Serial frame deframer input stage
// Registers one received byte and releases it when the result side is free.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfd_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  sfd_in_if.sink        in_ch,
  input  logic          out_free,
  output sfd_pkg::stage_t stage
);
  import sfd_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       step;
  logic       load;

  assign step        = valid_r && out_free;
  assign in_ch.ready = !valid_r || out_free;
  assign load        = in_ch.valid && in_ch.ready;
  assign valid_nxt   = load ? 1'b1 : (valid_r && !step);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_ch.rx_byte;
    end
  end

  assign stage.step    = step;
  assign stage.rx_byte = byte_r;

`include "serial_frame_deframer_top_macros.svh"

  `SFD_ASSERT(a_held_byte_kept, clk, rst_n, valid_r && !step |=> valid_r, "held beat lost")
  `SFD_ASSERT(a_accept_fills, clk, rst_n, load |=> valid_r, "accepted beat not registered")

endmodule

// ===== design/sfd_parser.sv =====
// ---------------------------------------------------------------------------
// Serial frame deframer parser
// Nine-phase frame state machine that captures the header and forms results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfd_parser #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sfd_pkg::cfg_t      cfg,
  input  sfd_pkg::stage_t    stage,
  output sfd_pkg::parse_out_t po
);
  import sfd_pkg::*;

  localparam logic [7:0] MaxIdx = 8'(MAX_PAYLOAD);

  phase_t      phase_r, phase_nxt;
  logic [15:0] cmd_r, cmd_nxt;
  logic [7:0]  node_r, node_nxt;
  logic [15:0] ext_r, ext_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic        err_r, err_nxt;
  logic [7:0]  b;
  logic [7:0]  idx_inc;
  logic        in_range;
  logic        bad_stop;

  assign b        = stage.rx_byte;
  assign idx_inc  = 8'(idx_r + 8'd1);
  assign in_range = idx_r < MaxIdx;
  assign bad_stop = b != cfg.stop_byte;

  always_comb begin
    phase_nxt = phase_r;
    if (stage.step) begin
      unique case (phase_r)
        PH_IDLE:    phase_nxt = (b == cfg.start_byte) ? PH_CMD_HI : PH_IDLE;
        PH_CMD_HI:  phase_nxt = PH_CMD_LO;
        PH_CMD_LO:  phase_nxt = PH_NODE;
        PH_NODE:    phase_nxt = PH_EXT_HI;
        PH_EXT_HI:  phase_nxt = PH_EXT_LO;
        PH_EXT_LO:  phase_nxt = PH_LENGTH;
        PH_LENGTH:  phase_nxt = (b != 8'd0) ? PH_PAYLOAD : PH_STOP;
        PH_PAYLOAD: phase_nxt = (idx_inc == len_r) ? PH_STOP : PH_PAYLOAD;
        PH_STOP:    phase_nxt = PH_IDLE;
        default:    phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_nxt  = cmd_r;
    node_nxt = node_r;
    ext_nxt  = ext_r;
    len_nxt  = len_r;
    idx_nxt  = idx_r;
    err_nxt  = err_r;
    po.en    = 1'b0;
    po.res   = '{kind: KIND_PAYLOAD, command: cmd_r, node_id: node_r, ext_id: ext_r,
                 payload_length: len_r, payload_index: 8'd0, payload_byte: 8'd0,
                 frame_error: 1'b0};
    if (stage.step) begin
      unique case (phase_r)
        PH_IDLE: begin
        end
        PH_CMD_HI: begin
          cmd_nxt = {8'd0, b};
          err_nxt = 1'b0;
        end
        PH_CMD_LO:  cmd_nxt  = {cmd_r[7:0], b};
        PH_NODE:    node_nxt = b;
        PH_EXT_HI:  ext_nxt  = {8'd0, b};
        PH_EXT_LO:  ext_nxt  = {ext_r[7:0], b};
        PH_LENGTH: begin
          len_nxt = b;
          if (b != 8'd0) begin
            idx_nxt = 8'd0;
          end
        end
        PH_PAYLOAD: begin
          idx_nxt = idx_inc;
          if (in_range) begin
            po.en                   = 1'b1;
            po.res.payload_index    = idx_r;
            po.res.payload_byte     = b;
          end else begin
            err_nxt = 1'b1;
          end
        end
        PH_STOP: begin
          err_nxt            = err_r || bad_stop;
          po.en              = 1'b1;
          po.res.kind        = KIND_END;
          po.res.frame_error = err_r || bad_stop;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    node_r <= node_nxt;
    ext_r  <= ext_nxt;
    len_r  <= len_nxt;
    idx_r  <= idx_nxt;
    err_r  <= err_nxt;
  end

`include "serial_frame_deframer_top_macros.svh"

  `SFD_ASSERT(a_stop_ends_frame, clk, rst_n, stage.step && phase_r == PH_STOP |-> po.en && po.res.kind == KIND_END, "stop position gave no frame end")
  `SFD_ASSERT(a_stop_to_idle, clk, rst_n, stage.step && phase_r == PH_STOP |=> phase_r == PH_IDLE, "deframer did not return to idle")
  `SFD_ASSERT(a_index_in_buffer, clk, rst_n, po.en && po.res.kind == KIND_PAYLOAD |-> po.res.payload_index < MaxIdx, "payload index beyond buffer")

endmodule

// ===== design/sfd_out_stage.sv =====
// ---------------------------------------------------------------------------
// Serial frame deframer output stage
// Result register that holds one result until the receiver takes it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfd_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  sfd_pkg::parse_out_t po,
  output logic               out_free,
  sfd_out_if.source          out_ch
);
  import sfd_pkg::*;

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  assign out_free  = !valid_r || out_ch.ready;
  assign valid_nxt = po.en ? 1'b1 : (valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (po.en) begin
      res_r <= po.res;
    end
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.kind           = res_r.kind;
  assign out_ch.command        = res_r.command;
  assign out_ch.node_id        = res_r.node_id;
  assign out_ch.ext_id         = res_r.ext_id;
  assign out_ch.payload_length = res_r.payload_length;
  assign out_ch.payload_index  = res_r.payload_index;
  assign out_ch.payload_byte   = res_r.payload_byte;
  assign out_ch.frame_error    = res_r.frame_error;

`include "serial_frame_deframer_top_macros.svh"

  `SFD_ASSERT(a_no_overwrite, clk, rst_n, po.en |-> out_free, "result register overwritten while full")
  `SFD_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !valid_r, "result valid after reset")

endmodule

// ===== design/serial_frame_deframer_top.sv =====
// ---------------------------------------------------------------------------
// Serial frame deframer
// Turns received serial bytes into payload-byte and frame-end results.
// ---------------------------------------------------------------------------
// Bytes arrive as beats on in_ch, one byte per beat. Results leave on out_ch:
// a payload-byte result for each payload byte below MAX_PAYLOAD, and a
// frame-end result at the stop position carrying the header and error flag.
// The start and stop byte values are written through cfg_we, cfg_index and
// cfg_wdata, by the user only while the block is idle (not enforced by the
// block); indexes other than the two registers are ignored.
// A byte is registered on acceptance and parsed once it leaves the input
// register; a byte that gives a result loads the result register then.
// One byte per cycle is sustained while the receiver takes every result
// beat; the parser state update between the two registers is combinational.
// While the receiver stalls, the result register holds its beat and the next
// byte waits in the input register, whether or not it would give a result,
// so in_ch.ready stays low until the result beat is taken.
// Reset empties both registers, returns the parser to waiting for a start
// byte and restores start byte 91 and stop byte 93.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_frame_deframer_top #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  sfd_in_if.sink                          in_ch,
  sfd_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sfd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import sfd_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  stage_t     stage;
  parse_out_t po;
  logic       out_free;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_START_BYTE: cfg_nxt.start_byte = cfg_wdata;
        REG_STOP_BYTE:  cfg_nxt.stop_byte  = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte <= 8'd91;
      cfg_r.stop_byte  <= 8'd93;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sfd_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_free (out_free),
    .stage    (stage)
  );

  sfd_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .stage (stage),
    .po    (po)
  );

  sfd_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .po       (po),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

endmodule

// ===== verif/serial_frame_deframer_top_tb.sv =====
// ---------------------------------------------------------------------------
// Serial frame deframer testbench
// Sends framed and stray bytes as beats and predicts every payload and
// frame-end result. Each result beat is compared field by field with the
// prediction. Start and stop byte settings change between bursts, and
// random stalls are applied on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_frame_deframer_top_tb;
  import sfd_pkg::*;

  localparam int MAX_PAYLOAD = 64;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [7:0] RESET_START_BYTE = 8'd91;
  localparam logic [7:0] RESET_STOP_BYTE = 8'd93;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST = '1;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sfd_in_if in_ch ();
  sfd_out_if out_ch ();

  serial_frame_deframer_top #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  logic [7:0] pending_bytes[$];
  res_t expected_results[$];

  phase_t parse_state;
  logic [15:0] frame_cmd;
  logic [7:0] frame_node;
  logic [15:0] frame_ext;
  logic [7:0] frame_len;
  logic [7:0] payload_pos;
  logic frame_bad;
  logic [7:0] start_value;
  logic [7:0] stop_value;

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int bytes_sent;
  int payload_results;
  int frame_ends;
  int flagged_ends;
  int cycle_count;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic void deframe_byte(input logic [7:0] b);
    case (parse_state)
      PH_IDLE: begin
        if (b == start_value) parse_state = PH_CMD_HI;
      end
      PH_CMD_HI: begin
        frame_cmd = {8'h00, b};
        frame_bad = 1'b0;
        parse_state = PH_CMD_LO;
      end
      PH_CMD_LO: begin
        frame_cmd = {frame_cmd[7:0], b};
        parse_state = PH_NODE;
      end
      PH_NODE: begin
        frame_node = b;
        parse_state = PH_EXT_HI;
      end
      PH_EXT_HI: begin
        frame_ext = {8'h00, b};
        parse_state = PH_EXT_LO;
      end
      PH_EXT_LO: begin
        frame_ext = {frame_ext[7:0], b};
        parse_state = PH_LENGTH;
      end
      PH_LENGTH: begin
        frame_len = b;
        if (b != 8'd0) begin
          payload_pos = 8'd0;
          parse_state = PH_PAYLOAD;
        end else begin
          parse_state = PH_STOP;
        end
      end
      PH_PAYLOAD: begin
        if (payload_pos < MAX_PAYLOAD) begin
          expected_results.push_back(res_t'({KIND_PAYLOAD, frame_cmd, frame_node,
                                             frame_ext, frame_len, payload_pos, b,
                                             1'b0}));
        end else begin
          frame_bad = 1'b1;
        end
        payload_pos = payload_pos + 8'd1;
        if (payload_pos == frame_len) parse_state = PH_STOP;
      end
      PH_STOP: begin
        if (b != stop_value) frame_bad = 1'b1;
        expected_results.push_back(res_t'({KIND_END, frame_cmd, frame_node, frame_ext,
                                           frame_len, 8'd0, 8'd0, frame_bad}));
        parse_state = PH_IDLE;
      end
      default: parse_state = PH_IDLE;
    endcase
  endfunction

  // Queues stray bytes now and then, followed by one frame; returns the frame length in
  // bytes. Short payloads dominate, with occasional overflow lengths.
  function automatic int queue_frame(input int fixed_len);
    int len;
    int pick;
    int noise;
    logic [7:0] closing;
    noise = ($urandom_range(99) < 15) ? $urandom_range(3, 1) : 0;
    repeat (noise) pending_bytes.push_back(8'($urandom_range(255)));
    pick = $urandom_range(99);
    if (fixed_len >= 0) len = fixed_len;
    else if (pick < 80) len = $urandom_range(6, 0);
    else if (pick < 94) len = $urandom_range(20, 7);
    else if (pick < 99) len = $urandom_range(70, 62);
    else len = 255;
    pending_bytes.push_back(start_value);
    repeat (5) pending_bytes.push_back(8'($urandom_range(255)));
    pending_bytes.push_back(8'(len));
    repeat (len) pending_bytes.push_back(8'($urandom_range(255)));
    closing = ($urandom_range(99) < 85) ? stop_value : 8'($urandom_range(255));
    pending_bytes.push_back(closing);
    return len + 8;
  endfunction

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == REG_START_BYTE) start_value = value;
    else if (idx == REG_STOP_BYTE) stop_value = value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_frames(input int budget, input bit hold_midway, input int first_len);
    int queued;
    bit held;
    held = 1'b0;
    queued = queue_frame(first_len);
    while (queued < budget) begin
      queued += queue_frame(-1);
      if (hold_midway && !held && queued >= budget / 2) begin
        held = 1'b1;
        wait_drained();
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        deframe_byte(in_ch.rx_byte);
        bytes_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.rx_byte <= pending_bytes.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    res_t seen;
    res_t want;
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen = {out_ch.kind, out_ch.command, out_ch.node_id, out_ch.ext_id,
              out_ch.payload_length, out_ch.payload_index, out_ch.payload_byte,
              out_ch.frame_error};
      if (expected_results.size() == 0) begin
        $display("%0t ns: unexpected result beat, expected none actual %p", $time, seen);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("kind", want.kind, seen.kind);
        check_field("command", want.command, seen.command);
        check_field("node_id", want.node_id, seen.node_id);
        check_field("ext_id", want.ext_id, seen.ext_id);
        check_field("payload_length", want.payload_length, seen.payload_length);
        check_field("payload_index", want.payload_index, seen.payload_index);
        check_field("payload_byte", want.payload_byte, seen.payload_byte);
        check_field("frame_error", want.frame_error, seen.frame_error);
        if (seen.kind == KIND_END) begin
          frame_ends++;
          if (seen.frame_error) flagged_ends++;
        end else begin
          payload_results++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t ns: timed out with %0d results outstanding", $time,
               expected_results.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_START_BYTE;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = 8'h00;
    out_ch.ready = 1'b0;
    parse_state = PH_IDLE;
    frame_cmd = '0;
    frame_node = '0;
    frame_ext = '0;
    frame_len = '0;
    payload_pos = '0;
    frame_bad = 1'b0;
    start_value = RESET_START_BYTE;
    stop_value = RESET_STOP_BYTE;
    send_idle_pct = 8;
    recv_idle_pct = 87;
    mismatches = 0;
    bytes_sent = 0;
    payload_results = 0;
    frame_ends = 0;
    flagged_ends = 0;
    cycle_count = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // A stray byte, an all-ones header with no payload, a frame with an all-zeros header
    // and a bad stop byte, then a clean frame to show the error flag starts afresh.
    pending_bytes = '{8'h00,
                      RESET_START_BYTE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00,
                      RESET_STOP_BYTE,
                      RESET_START_BYTE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02,
                      8'h00, 8'hFF, 8'h00,
                      RESET_START_BYTE, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'h00,
                      RESET_STOP_BYTE};
    wait_drained();

    write_reg(REG_START_BYTE, 8'h00);
    write_reg(REG_STOP_BYTE, 8'hFF);
    write_reg(REG_SPARE_FIRST, 8'hA5);
    write_reg(REG_SPARE_LAST, 8'h3C);
    send_frames(265, 1'b1, 66);
    wait_drained();

    send_idle_pct = 87;
    recv_idle_pct = 8;
    write_reg(REG_START_BYTE, 8'hFF);
    write_reg(REG_STOP_BYTE, 8'h00);
    send_frames(265, 1'b0, 65);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_START_BYTE, 8'h7E);
    write_reg(REG_STOP_BYTE, 8'h7E);
    send_frames(265, 1'b0, 255);
    wait_drained();

    $display("Sent %0d bytes under four start/stop settings and three stall profiles.",
             bytes_sent);
    $display("Checked %0d payload results and %0d frame ends, %0d of them flagged.",
             payload_results, frame_ends, flagged_ends);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
